FILE: rtl/bvr_pkg.sv
// Shared types and constants for the bounded vector with reverse.
package bvr_pkg;

    localparam int DEPTH_DEF = 1024;
    localparam int WORD_W    = 32;
    localparam int IDX_W     = 12;
    localparam int OP_W      = 2;
    localparam int STAT_W    = 2;
    localparam int CNT_OUT_W = 11;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH    = 2'd0,
        OP_GET     = 2'd1,
        OP_SET     = 2'd2,
        OP_REVERSE = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Controller to datapath, at most one member high per cycle.
    typedef struct packed {
        logic capture;
        logic exec;
        logic rev_rd_lo;
        logic rev_rd_hi;
        logic rev_wr_lo;
        logic rev_wr_hi;
        logic load_out;
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        op_t  op;
        logic rev_more;
    } dp_stat_t;

endpackage

FILE: rtl/bvr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bvr_ram #(
    parameter int WIDTH = bvr_pkg::WORD_W,
    parameter int DEPTH = bvr_pkg::DEPTH_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem_reg[raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/bvr_dp.sv
// Datapath: item registers, count and capacity, reverse pointers, element store, result registers.
module bvr_dp #(
    parameter int DEPTH = bvr_pkg::DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  bvr_pkg::dp_cmd_t                     cmd,
    output bvr_pkg::dp_stat_t                    stat,
    input  logic [bvr_pkg::OP_W-1:0]             opcode,
    input  logic signed [bvr_pkg::IDX_W-1:0]     index,
    input  logic signed [bvr_pkg::WORD_W-1:0]    value,
    output logic signed [bvr_pkg::WORD_W-1:0]    read_value,
    output logic [bvr_pkg::STAT_W-1:0]           status,
    output logic [bvr_pkg::CNT_OUT_W-1:0]        fill_count,
    output logic [bvr_pkg::CNT_OUT_W-1:0]        capacity_now
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > bvr_pkg::CNT_OUT_W) ? CNT_W : bvr_pkg::CNT_OUT_W;
    localparam int WORD_W = bvr_pkg::WORD_W;

    bvr_pkg::op_t               op_reg, op_next;
    logic [bvr_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic [WORD_W-1:0]          val_reg, val_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [CNT_W-1:0]           cap_reg, cap_next;
    logic [CNT_W-1:0]           lo_reg, lo_next;
    logic [CNT_W-1:0]           hi_reg, hi_next;
    logic [WORD_W-1:0]          tmp_reg, tmp_next;
    bvr_pkg::status_t           pend_reg, pend_next;
    logic [WORD_W-1:0]          rdv_reg, rdv_next;
    logic [bvr_pkg::STAT_W-1:0] stat_out_reg, stat_out_next;
    logic [CMP_W-1:0]           fill_reg, fill_next;
    logic [CMP_W-1:0]           capo_reg, capo_next;

    logic [CMP_W-1:0]  idx_ext;
    logic              in_range;
    logic              full;
    logic [CNT_W-1:0]  lo_inc;
    logic [CNT_W-1:0]  hi_last;
    logic [CNT_W:0]    grown;
    logic [CNT_W-1:0]  grown_cap;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    // Index sign bit is checked separately; the magnitude bits compare against the count.
    assign idx_ext  = CMP_W'(idx_reg[bvr_pkg::IDX_W-2:0]);
    assign in_range = !idx_reg[bvr_pkg::IDX_W-1] && (idx_ext < CMP_W'(count_reg));
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign lo_inc   = lo_reg + CNT_W'(1);
    assign hi_last  = hi_reg - CNT_W'(1);
    assign grown    = {cap_reg, 1'b0};
    assign grown_cap = (grown > (CNT_W + 1)'(DEPTH)) ? CNT_W'(DEPTH) : grown[CNT_W-1:0];

    assign stat.op       = op_reg;
    assign stat.rev_more = (lo_inc < hi_reg);

    always_comb
    begin
        op_next       = op_reg;
        idx_next      = idx_reg;
        val_next      = val_reg;
        count_next    = count_reg;
        cap_next      = cap_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        tmp_next      = tmp_reg;
        pend_next     = pend_reg;
        rdv_next      = rdv_reg;
        stat_out_next = stat_out_reg;
        fill_next     = fill_reg;
        capo_next     = capo_reg;
        ram_we        = 1'b0;
        ram_waddr     = lo_reg[ADDR_W-1:0];
        ram_wdata     = val_reg;
        ram_re        = 1'b0;
        ram_raddr     = lo_reg[ADDR_W-1:0];

        if (cmd.capture)
        begin
            op_next  = bvr_pkg::op_t'(opcode);
            idx_next = index;
            val_next = value;
            lo_next  = '0;
            hi_next  = count_reg;
        end
        else if (cmd.exec)
        begin
            case (op_reg)
                bvr_pkg::OP_PUSH:
                begin
                    if (full)
                    begin
                        pend_next = bvr_pkg::ST_FULL;
                    end
                    else
                    begin
                        pend_next  = bvr_pkg::ST_OK;
                        ram_we     = 1'b1;
                        ram_waddr  = count_reg[ADDR_W-1:0];
                        count_next = count_reg + CNT_W'(1);
                        if (count_reg >= cap_reg)
                        begin
                            cap_next = grown_cap;
                        end
                    end
                end
                bvr_pkg::OP_GET:
                begin
                    pend_next = in_range ? bvr_pkg::ST_OK : bvr_pkg::ST_RANGE;
                    ram_re    = in_range;
                    ram_raddr = idx_ext[ADDR_W-1:0];
                end
                bvr_pkg::OP_SET:
                begin
                    pend_next = in_range ? bvr_pkg::ST_OK : bvr_pkg::ST_RANGE;
                    ram_we    = in_range;
                    ram_waddr = idx_ext[ADDR_W-1:0];
                end
                default:
                begin
                    pend_next = bvr_pkg::ST_OK;
                end
            endcase
        end
        else if (cmd.rev_rd_lo)
        begin
            ram_re    = 1'b1;
            ram_raddr = lo_reg[ADDR_W-1:0];
        end
        else if (cmd.rev_rd_hi)
        begin
            // low word arrives now; park it while the high word is fetched
            ram_re    = 1'b1;
            ram_raddr = hi_last[ADDR_W-1:0];
            tmp_next  = ram_rdata;
        end
        else if (cmd.rev_wr_lo)
        begin
            ram_we    = 1'b1;
            ram_waddr = lo_reg[ADDR_W-1:0];
            ram_wdata = ram_rdata;
        end
        else if (cmd.rev_wr_hi)
        begin
            ram_we    = 1'b1;
            ram_waddr = hi_last[ADDR_W-1:0];
            ram_wdata = tmp_reg;
            lo_next   = lo_inc;
            hi_next   = hi_last;
        end
        else if (cmd.load_out)
        begin
            if (op_reg == bvr_pkg::OP_GET)
            begin
                rdv_next = (pend_reg == bvr_pkg::ST_OK) ? ram_rdata : '1;
            end
            else
            begin
                rdv_next = '0;
            end
            stat_out_next = pend_reg;
            fill_next     = CMP_W'(count_reg);
            capo_next     = CMP_W'(cap_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cap_reg   <= CNT_W'(1);
        end
        else
        begin
            count_reg <= count_next;
            cap_reg   <= cap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        idx_reg      <= idx_next;
        val_reg      <= val_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        tmp_reg      <= tmp_next;
        pend_reg     <= pend_next;
        rdv_reg      <= rdv_next;
        stat_out_reg <= stat_out_next;
        fill_reg     <= fill_next;
        capo_reg     <= capo_next;
    end

    bvr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (ram_re),
        .raddr   (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign read_value   = rdv_reg;
    assign status       = stat_out_reg;
    assign fill_count   = fill_reg[bvr_pkg::CNT_OUT_W-1:0];
    assign capacity_now = capo_reg[bvr_pkg::CNT_OUT_W-1:0];

endmodule

FILE: rtl/bvr_ctrl.sv
// Controller: sequences each operation and the reverse swap loop, owns the output valid.
module bvr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  bvr_pkg::dp_stat_t stat,
    output bvr_pkg::dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_REV_A,
        S_REV_B,
        S_REV_C,
        S_REV_D,
        S_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = (stat.op == bvr_pkg::OP_REVERSE) ? S_REV_A : S_RESULT;
            end
            S_REV_A:
            begin
                if (stat.rev_more)
                begin
                    cmd.rev_rd_lo = 1'b1;
                    state_next    = S_REV_B;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_REV_B:
            begin
                cmd.rev_rd_hi = 1'b1;
                state_next    = S_REV_C;
            end
            S_REV_C:
            begin
                cmd.rev_wr_lo = 1'b1;
                state_next    = S_REV_D;
            end
            S_REV_D:
            begin
                cmd.rev_wr_hi = 1'b1;
                state_next    = S_REV_A;
            end
            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: rtl/bounded_vector_with_reverse.sv
// Top level of the bounded vector with reverse: controller plus datapath.
//
//  channel  handshake           payload
//  in       in_valid/in_ready   opcode[1:0], index[11:0] signed, value[31:0] signed
//  out      out_valid/out_ready read_value[31:0] signed, status[1:0], fill_count[10:0],
//                               capacity_now[10:0]
//
// Push, get and set hold the input side through accept, execute and result load.
// Reverse runs floor(count/2) swaps: each swap is two reads and two writes
// through the single read and single write port of the element store.
// A finished result sits in the output register while the next item is accepted;
// a stalled output holds only the following result load.
// Reset (rst_n, async) empties the vector and sets capacity to one; the store is not cleared.
module bounded_vector_with_reverse #(
    parameter int DEPTH = bvr_pkg::DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [bvr_pkg::OP_W-1:0]          opcode,
    input  logic signed [bvr_pkg::IDX_W-1:0]  index,
    input  logic signed [bvr_pkg::WORD_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [bvr_pkg::WORD_W-1:0] read_value,
    output logic [bvr_pkg::STAT_W-1:0]        status,
    output logic [bvr_pkg::CNT_OUT_W-1:0]     fill_count,
    output logic [bvr_pkg::CNT_OUT_W-1:0]     capacity_now
);

    bvr_pkg::dp_cmd_t  cmd;
    bvr_pkg::dp_stat_t stat;

    bvr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bvr_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .opcode       (opcode),
        .index        (index),
        .value        (value),
        .read_value   (read_value),
        .status       (status),
        .fill_count   (fill_count),
        .capacity_now (capacity_now)
    );

endmodule

FILE: verif/tb_bounded_vector_with_reverse.sv
// Testbench for bounded_vector_with_reverse: random and directed vector ops, scoreboard check.
`timescale 1ns / 100ps

module tb_bounded_vector_with_reverse;

    localparam int          STORE_DEPTH = bvr_pkg::DEPTH_DEF;
    localparam int          SB_AW       = $clog2(STORE_DEPTH);
    localparam int          WORD_W      = bvr_pkg::WORD_W;
    localparam int          IDX_W       = bvr_pkg::IDX_W;
    localparam int          OP_W        = bvr_pkg::OP_W;
    localparam int          STAT_W      = bvr_pkg::STAT_W;
    localparam int          CNT_OUT_W   = bvr_pkg::CNT_OUT_W;
    localparam int          LONG_HOLD   = 400;
    localparam int          DRAIN_WAIT  = 32;
    localparam int          MIXED_ITEMS = 150;
    localparam int          FULL_ITEMS  = 40;
    localparam int unsigned LIMIT       = 12_000_000;

    typedef struct {
        logic [WORD_W-1:0]    rd;
        bvr_pkg::status_t     st;
        logic [CNT_OUT_W-1:0] fill;
        logic [CNT_OUT_W-1:0] cap;
    } vec_result_t;

    // Shadow copy of the vector plus the queue of results still owed by the block.
    class vector_scoreboard;
        logic [WORD_W-1:0] words [STORE_DEPTH];
        int unsigned       count = 0;
        int unsigned       cap = 1;
        vec_result_t       pending [$];
        int unsigned       errors = 0;
        int unsigned       checked = 0;
        int unsigned       n_full = 0;
        int unsigned       n_range = 0;
        int unsigned       n_rev = 0;
        int unsigned       max_rev = 0;

        function void note(bvr_pkg::op_t op, logic [IDX_W-1:0] idx, logic [WORD_W-1:0] val);
            vec_result_t       r;
            bit                hit;
            int unsigned       pos;
            int unsigned       lo;
            int unsigned       hi;
            logic [WORD_W-1:0] t;
            r.rd = '0;
            r.st = bvr_pkg::ST_OK;
            pos  = 32'(idx[IDX_W-2:0]);
            hit  = !idx[IDX_W-1] && (pos < count);
            case (op)
                bvr_pkg::OP_PUSH:
                    if (count >= STORE_DEPTH)
                    begin
                        r.st = bvr_pkg::ST_FULL;
                        n_full++;
                    end
                    else
                    begin
                        if (count >= cap)
                            cap = (cap * 2 > STORE_DEPTH) ? STORE_DEPTH : cap * 2;
                        words[SB_AW'(count)] = val;
                        count++;
                    end
                bvr_pkg::OP_GET:
                    if (hit)
                        r.rd = words[SB_AW'(pos)];
                    else
                    begin
                        r.rd = '1;
                        r.st = bvr_pkg::ST_RANGE;
                        n_range++;
                    end
                bvr_pkg::OP_SET:
                    if (hit)
                        words[SB_AW'(pos)] = val;
                    else
                    begin
                        r.st = bvr_pkg::ST_RANGE;
                        n_range++;
                    end
                default:
                begin
                    lo = 0;
                    hi = count;
                    while (lo + 1 < hi)
                    begin
                        hi--;
                        t                   = words[SB_AW'(lo)];
                        words[SB_AW'(lo)]   = words[SB_AW'(hi)];
                        words[SB_AW'(hi)]   = t;
                        lo++;
                    end
                    n_rev++;
                    if (count > max_rev)
                        max_rev = count;
                end
            endcase
            r.fill = count[CNT_OUT_W-1:0];
            r.cap  = cap[CNT_OUT_W-1:0];
            pending.push_back(r);
        endfunction

        function void mismatch(string field, logic [WORD_W-1:0] exp_v, logic [WORD_W-1:0] act_v);
            errors++;
            if (errors <= 10)
                $display("[%0t] mismatch on %s: expected %0h, got %0h (result %0d)",
                         $realtime, field, exp_v, act_v, checked);
        endfunction

        function void check(logic [WORD_W-1:0] rd, logic [STAT_W-1:0] st,
                            logic [CNT_OUT_W-1:0] fill, logic [CNT_OUT_W-1:0] capn);
            vec_result_t e;
            if (pending.size() == 0)
            begin
                mismatch("unexpected result", '0, rd);
                return;
            end
            e = pending.pop_front();
            if (rd !== e.rd)
                mismatch("read_value", e.rd, rd);
            if (st !== e.st)
                mismatch("status", WORD_W'(e.st), WORD_W'(st));
            if (fill !== e.fill)
                mismatch("fill_count", WORD_W'(e.fill), WORD_W'(fill));
            if (capn !== e.cap)
                mismatch("capacity_now", WORD_W'(e.cap), WORD_W'(capn));
            checked++;
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [OP_W-1:0]            opcode = '0;
    logic signed [IDX_W-1:0]    index = '0;
    logic signed [WORD_W-1:0]   value = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [WORD_W-1:0]   read_value;
    logic [STAT_W-1:0]          status;
    logic [CNT_OUT_W-1:0]       fill_count;
    logic [CNT_OUT_W-1:0]       capacity_now;

    vector_scoreboard score;
    bit               steady = 1'b0;
    bit               hold_req = 1'b0;
    int unsigned      items_sent = 0;
    int unsigned      holds_done = 0;
    int unsigned      cycle_count = 0;

    bounded_vector_with_reverse dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .index        (index),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_value   (read_value),
        .status       (status),
        .fill_count   (fill_count),
        .capacity_now (capacity_now)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("tb_bounded_vector_with_reverse NOT OK");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(31))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Mostly valid positions, then the first position past the end, then anything at all.
    function automatic logic [IDX_W-1:0] pick_index();
        int unsigned r;
        r = $urandom_range(99);
        if (score.count > 0 && r < 75)
            return IDX_W'($urandom_range(score.count - 1));
        if (r < 85)
            return IDX_W'(score.count);
        return IDX_W'($urandom);
    endfunction

    task automatic pause_sender(int unsigned n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Called at a rising edge; returns at the edge where the transfer happened.
    task automatic drive_item(bvr_pkg::op_t op, logic [IDX_W-1:0] idx, logic [WORD_W-1:0] val);
        pause_sender(steady ? 0 : pick_gap());
        in_valid <= 1'b1;
        opcode   <= op;
        index    <= idx;
        value    <= val;
        do
            @(posedge clk);
        while (!in_ready);
        score.note(op, idx, val);
        items_sent++;
    endtask

    task automatic random_item(int unsigned push_pct, int unsigned rev_pct);
        int unsigned       r;
        bvr_pkg::op_t      op;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] val;
        r   = $urandom_range(99);
        idx = IDX_W'($urandom);
        val = pick_word();
        if (r < push_pct)
            op = bvr_pkg::OP_PUSH;
        else if (r < push_pct + rev_pct)
            op = bvr_pkg::OP_REVERSE;
        else
        begin
            op  = $urandom_range(1) ? bvr_pkg::OP_GET : bvr_pkg::OP_SET;
            idx = pick_index();
        end
        drive_item(op, idx, val);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (score.pending.size() != 0)
            @(posedge clk);
    endtask

    // Output side: random stalls, calm stretches, and one long hold-off on request.
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                score.check(read_value, status, fill_count, capacity_now);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (hold_req)
            begin
                hold_req   = 1'b0;
                out_ready  <= 1'b0;
                stall_left = LONG_HOLD - 1;
                holds_done++;
            end
            else if (!steady && $urandom_range(99) < 15)
            begin
                out_ready  <= 1'b0;
                stall_left = ($urandom_range(99) < 85) ? $urandom_range(0, 2)
                                                       : $urandom_range(7, 39);
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        score = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty vector, capacity growth, range edges, reverses of empty and odd-length vectors.
        drive_item(bvr_pkg::OP_REVERSE, 12'h000, 32'h0);
        drive_item(bvr_pkg::OP_GET,     12'h000, 32'h0);
        drive_item(bvr_pkg::OP_SET,     12'h000, 32'h1234_5678);
        drive_item(bvr_pkg::OP_PUSH,    12'hFFF, 32'h7FFF_FFFF);
        drive_item(bvr_pkg::OP_REVERSE, 12'hFFF, 32'hFFFF_FFFF);
        drive_item(bvr_pkg::OP_GET,     12'h000, 32'h0);
        drive_item(bvr_pkg::OP_PUSH,    12'h000, 32'h8000_0000);
        drive_item(bvr_pkg::OP_PUSH,    12'h000, 32'hFFFF_FFFF);
        drive_item(bvr_pkg::OP_GET,     12'h800, 32'h0);
        drive_item(bvr_pkg::OP_GET,     12'h7FF, 32'h0);
        drive_item(bvr_pkg::OP_GET,     12'h002, 32'h0);
        drive_item(bvr_pkg::OP_GET,     12'h003, 32'h0);
        drive_item(bvr_pkg::OP_SET,     12'h001, 32'h0000_0000);
        drive_item(bvr_pkg::OP_SET,     12'hFFF, 32'hDEAD_BEEF);
        drive_item(bvr_pkg::OP_REVERSE, 12'h000, 32'h0);
        drive_item(bvr_pkg::OP_GET,     12'h000, 32'h0);
        drive_item(bvr_pkg::OP_GET,     12'h001, 32'h0);
        drive_item(bvr_pkg::OP_GET,     12'h002, 32'h0);
        drive_item(bvr_pkg::OP_PUSH,    12'h000, 32'h0000_0000);
        drive_item(bvr_pkg::OP_PUSH,    12'h000, 32'h0000_3039);
        drive_item(bvr_pkg::OP_REVERSE, 12'h000, 32'h0);
        drive_item(bvr_pkg::OP_GET,     12'h004, 32'h0);
        drive_item(bvr_pkg::OP_GET,     12'h000, 32'h0);

        // Sender waits for every result before the random part.
        wait_drained();
        @(posedge clk);

        for (int i = 0; i < MIXED_ITEMS; i++)
        begin
            if (i % 64 == 0)
                steady = ($urandom_range(3) == 0);
            if (i == 60)
                hold_req = 1'b1;
            random_item(55, 4);
        end

        // Grow the vector to the top so that capacity saturates and pushes bounce.
        steady = 1'b0;
        for (int i = 0; score.count < STORE_DEPTH; i++)
        begin
            if (i % 64 == 0)
                steady = ($urandom_range(3) == 0);
            random_item(96, 1);
        end
        for (int i = 0; i < FULL_ITEMS; i++)
            random_item(50, 5);

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Ran %0d ops, %0d results checked; %0d reverses (longest %0d words),",
                 items_sent, score.checked, score.n_rev, score.max_rev);
        $display("%0d bad-index ops, %0d pushes into a full store, %0d long output hold-offs.",
                 score.n_range, score.n_full, holds_done);
        if (score.errors == 0)
            $display("tb_bounded_vector_with_reverse OK");
        else
            $display("tb_bounded_vector_with_reverse NOT OK");
        $finish;
    end

endmodule

FILE: files.f
rtl/bvr_pkg.sv
rtl/bvr_ram.sv
rtl/bvr_dp.sv
rtl/bvr_ctrl.sv
rtl/bounded_vector_with_reverse.sv
verif/tb_bounded_vector_with_reverse.sv
